### hdl/sled_pkg.sv
package sled_pkg;

  // input and result transactions
  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       missing_quote;
  } out_item_t;

  // scan modes of the decoder
  typedef enum logic [2:0] {
    MODE_PLAIN = 3'd0,
    MODE_ESC   = 3'd1,
    MODE_OCT   = 3'd2,
    MODE_HEX   = 3'd3,
    MODE_TRAIL = 3'd4
  } mode_e;

  // result queue sizing
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // characters with a meaning of their own
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LOW_X  = 8'h78;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_V  = 8'h76;
  localparam logic [7:0] CH_LOW_A  = 8'h61;

  // control codes for simple escapes
  localparam logic [7:0] CODE_NL  = 8'h0A;
  localparam logic [7:0] CODE_TAB = 8'h09;
  localparam logic [7:0] CODE_BS  = 8'h08;
  localparam logic [7:0] CODE_CR  = 8'h0D;
  localparam logic [7:0] CODE_FF  = 8'h0C;
  localparam logic [7:0] CODE_VT  = 8'h0B;
  localparam logic [7:0] CODE_BEL = 8'h07;

endpackage

### hdl/sled_decoder.sv
module sled_decoder import sled_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  in_item_t   item_i,
  input  logic       dbe_i,
  output logic [1:0] res_cnt_o,
  output out_item_t  res0_o,
  output out_item_t  res1_o
);

  typedef struct packed {
    logic      emit;
    out_item_t item;
    mode_e     mode;
  } plain_res_t;

  mode_e      mode_q, mode_d;
  logic [7:0] val_q, val_d;
  logic [1:0] cnt_q, cnt_d;
  plain_res_t pr;
  logic [7:0] c;
  logic       eoi;
  logic       is_oct;
  logic       is_hex;
  logic [3:0] hex_val;
  logic       is_lead;
  logic [7:0] esc_byte;
  logic [7:0] oct_next;
  logic [7:0] hex_next;

  assign c   = item_i.in_char;
  assign eoi = item_i.end_of_input;

  // character classes
  always_comb begin
    is_oct  = c inside {[8'h30:8'h37]};
    is_lead = c inside {[8'h81:8'h9F], [8'hE0:8'hFC]};
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      hex_val = c[3:0];
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      hex_val = 4'(c[2:0] + 3'd1) + 4'd8;
    end else begin
      is_hex = 1'b0;
    end
  end

  assign oct_next = {val_q[4:0], c[2:0]};
  assign hex_next = {val_q[3:0], hex_val};

  // simple escape letters
  always_comb begin
    case (c)
      CH_LOW_N: esc_byte = CODE_NL;
      CH_LOW_T: esc_byte = CODE_TAB;
      CH_LOW_B: esc_byte = CODE_BS;
      CH_LOW_R: esc_byte = CODE_CR;
      CH_LOW_F: esc_byte = CODE_FF;
      CH_LOW_V: esc_byte = CODE_VT;
      CH_LOW_A: esc_byte = CODE_BEL;
      default:  esc_byte = c;
    endcase
  end

  // plain text handling of the current character
  always_comb begin
    pr      = '0;
    pr.mode = MODE_PLAIN;
    if (eoi || c == CH_LF) begin
      pr.emit = 1'b1;
      pr.item = '{out_byte: 8'd0, last: 1'b1, missing_quote: 1'b1};
    end else if (c == CH_QUOTE) begin
      pr.emit = 1'b1;
      pr.item = '{out_byte: 8'd0, last: 1'b1, missing_quote: 1'b0};
    end else if (c == CH_BSLASH) begin
      pr.mode = MODE_ESC;
    end else begin
      pr.emit = 1'b1;
      pr.item = '{out_byte: c, last: 1'b0, missing_quote: 1'b0};
      if (dbe_i && is_lead) pr.mode = MODE_TRAIL;
    end
  end

  // state update and results
  always_comb begin
    mode_d    = mode_q;
    val_d     = val_q;
    cnt_d     = cnt_q;
    res_cnt_o = 2'd0;
    res0_o    = '0;
    res1_o    = '0;
    case (mode_q)
      MODE_ESC: begin
        mode_d = MODE_PLAIN;
        if (eoi) begin
          res0_o    = '{out_byte: 8'd0, last: 1'b1, missing_quote: 1'b1};
          res_cnt_o = 2'd1;
        end else if (c == CH_LF) begin
          // line continuation, nothing emitted
        end else if (is_oct) begin
          val_d  = {5'd0, c[2:0]};
          cnt_d  = 2'd1;
          mode_d = MODE_OCT;
        end else if (c == CH_LOW_X) begin
          val_d  = 8'd0;
          cnt_d  = 2'd0;
          mode_d = MODE_HEX;
        end else begin
          res0_o    = '{out_byte: esc_byte, last: 1'b0, missing_quote: 1'b0};
          res_cnt_o = 2'd1;
        end
      end
      MODE_OCT: begin
        if (!eoi && is_oct) begin
          val_d = oct_next;
          if (cnt_q == 2'd2) begin
            cnt_d     = 2'd0;
            mode_d    = MODE_PLAIN;
            res0_o    = '{out_byte: oct_next, last: 1'b0, missing_quote: 1'b0};
            res_cnt_o = 2'd1;
          end else begin
            cnt_d = cnt_q + 2'd1;
          end
        end else begin
          // escape ended early: pending value, then the character as text
          cnt_d     = 2'd0;
          mode_d    = pr.mode;
          res0_o    = '{out_byte: val_q, last: 1'b0, missing_quote: 1'b0};
          res1_o    = pr.item;
          res_cnt_o = pr.emit ? 2'd2 : 2'd1;
        end
      end
      MODE_HEX: begin
        if (!eoi && is_hex) begin
          val_d = hex_next;
          if (cnt_q == 2'd1) begin
            cnt_d     = 2'd0;
            mode_d    = MODE_PLAIN;
            res0_o    = '{out_byte: hex_next, last: 1'b0, missing_quote: 1'b0};
            res_cnt_o = 2'd1;
          end else begin
            cnt_d = cnt_q + 2'd1;
          end
        end else begin
          cnt_d     = 2'd0;
          mode_d    = pr.mode;
          res0_o    = '{out_byte: val_q, last: 1'b0, missing_quote: 1'b0};
          res1_o    = pr.item;
          res_cnt_o = pr.emit ? 2'd2 : 2'd1;
        end
      end
      MODE_TRAIL: begin
        mode_d    = MODE_PLAIN;
        res_cnt_o = 2'd1;
        if (eoi) begin
          res0_o = '{out_byte: 8'd0, last: 1'b1, missing_quote: 1'b1};
        end else begin
          res0_o = '{out_byte: c, last: 1'b0, missing_quote: 1'b0};
        end
      end
      default: begin
        mode_d    = pr.mode;
        res0_o    = pr.item;
        res_cnt_o = pr.emit ? 2'd1 : 2'd0;
      end
    endcase
  end

  // decoder state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PLAIN;
      val_q  <= 8'd0;
      cnt_q  <= 2'd0;
    end else if (step_i) begin
      mode_q <= mode_d;
      val_q  <= val_d;
      cnt_q  <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  // octal escape holds one or two digits between characters
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_OCT |-> (cnt_q == 2'd1 || cnt_q == 2'd2))
    else $error("octal digit count out of range");

  // hex escape holds at most one digit between characters
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_HEX |-> cnt_q <= 2'd1)
    else $error("hex digit count out of range");

  // a pair of results only comes from an escape cut short by a character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_cnt_o == 2'd2 |-> (!res0_o.last && (mode_q == MODE_OCT || mode_q == MODE_HEX)))
    else $error("unexpected result pair");
`endif

endmodule

### hdl/sled_out_fifo.sv
module sled_out_fifo import sled_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_cnt_i,
  input  out_item_t  push0_i,
  input  out_item_t  push1_i,
  output logic       space_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_item_o
);

  out_item_t             mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr_q, wptr_d;
  logic [FIFO_PTR_W-1:0] rptr_q, rptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;
  logic [FIFO_PTR_W-1:0] wptr_nx;
  logic                  pop;

  // room for a pair of results
  assign space_o     = count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2);
  assign out_valid_o = count_q != '0;
  assign out_item_o  = mem_q[rptr_q];
  assign pop         = out_valid_o && out_ready_i;
  assign wptr_nx     = wptr_q + FIFO_PTR_W'(1);

  // pointer and fill count update
  always_comb begin
    wptr_d  = wptr_q + FIFO_PTR_W'(push_cnt_i);
    rptr_d  = pop ? rptr_q + FIFO_PTR_W'(1) : rptr_q;
    count_d = count_q + FIFO_CNT_W'(push_cnt_i) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // result storage
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) mem_q[wptr_q] <= push0_i;
    if (push_cnt_i == 2'd2) mem_q[wptr_nx] <= push1_i;
  end

`ifndef SYNTHESIS
  // pushes only land when there is room for them
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_cnt_i != 2'd0 |-> count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2))
    else $error("push into a full result queue");

  // fill count tracks the pointers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FIFO_CNT_W'(FIFO_DEPTH) &&
    (wptr_q - rptr_q) == FIFO_PTR_W'(count_q))
    else $error("result queue count out of step with pointers");
`endif

endmodule

### hdl/string_literal_escape_decoder.sv
// C string literal escape decoder
//
// in channel: one source character per transaction (in_valid_i / in_ready_o),
//   starting after the opening quote; end_of_input marks the end of source.
// out channel: decoded bytes (out_valid_o / out_ready_i); each string closes
//   with a NUL result that has last set, and missing_quote set when it ended
//   on a newline or end of input instead of a closing quote.
// cfg channel: one write of double_byte_enable per transaction, always ready;
//   write it only while the block is idle.
// path: an accepted character is held in the input register, decoded from
//   there, and its results are written into the result queue that feeds out.
// throughput: one character per cycle while the queue has room, set by the
//   single decode stage; a character that ends an escape early can give two
//   results, which leave on out one after the other. The four-entry result
//   queue takes a decode only when it has room for two results.
// reset: plain text mode, queue empty, double_byte_enable = 1.
// stall: when out_ready_i is low results collect in the queue; once fewer
//   than two entries are free, a held character stays and in_ready_o drops.
module string_literal_escape_decoder import sled_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_data_i
);

  logic       in_valid_q;
  in_item_t   in_item_q;
  logic       dbe_q;
  logic       space;
  logic       step;
  logic [1:0] res_cnt;
  logic [1:0] push_cnt;
  out_item_t  res0;
  out_item_t  res1;

  // input register handshake
  assign step       = in_valid_q && space;
  assign in_ready_o = !in_valid_q || step;
  assign cfg_ready_o = 1'b1;
  assign push_cnt   = step ? res_cnt : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_item_q <= in_item_i;
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbe_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      dbe_q <= cfg_data_i;
    end
  end

  sled_decoder u_decoder (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .item_i    (in_item_q),
    .dbe_i     (dbe_q),
    .res_cnt_o (res_cnt),
    .res0_o    (res0),
    .res1_o    (res1)
  );

  sled_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .push0_i     (res0),
    .push1_i     (res1),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

### test/string_literal_decode_checker.sv
module string_literal_decode_checker
  import sled_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_item_i,
  input  logic      cfg_valid_i,
  input  logic      cfg_ready_i,
  input  logic      cfg_data_i,
  output int        fail_count_o,
  output int        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // digit and lead byte bounds
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] LEAD_LO1 = 8'h81;
  localparam logic [7:0] LEAD_HI1 = 8'h9F;
  localparam logic [7:0] LEAD_LO2 = 8'hE0;
  localparam logic [7:0] LEAD_HI2 = 8'hFC;

  // predicted decoder state
  logic       dbl_en;
  mode_e      mode;
  logic [7:0] esc_val;
  logic [1:0] digits;
  out_item_t  decoded_q[$];
  out_item_t  want;

  function automatic bit is_lead_byte(logic [7:0] c);
    return (c >= LEAD_LO1 && c <= LEAD_HI1) || (c >= LEAD_LO2 && c <= LEAD_HI2);
  endfunction

  function automatic int hex_value(logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= CH_UP_A && c <= CH_UP_F) return int'(c - CH_UP_A) + 10;
    if (c >= CH_LOW_A && c <= CH_LOW_F) return int'(c - CH_LOW_A) + 10;
    return -1;
  endfunction

  function automatic logic [7:0] escape_code(logic [7:0] c);
    case (c)
      CH_LOW_N: return CODE_NL;
      CH_LOW_T: return CODE_TAB;
      CH_LOW_B: return CODE_BS;
      CH_LOW_R: return CODE_CR;
      CH_LOW_F: return CODE_FF;
      CH_LOW_V: return CODE_VT;
      CH_LOW_A: return CODE_BEL;
      default:  return c;
    endcase
  endfunction

  task automatic push_byte(logic [7:0] b, logic lst, logic miss);
    out_item_t r;
    r.out_byte      = b;
    r.last          = lst;
    r.missing_quote = miss;
    decoded_q.push_back(r);
  endtask

  task automatic end_string(logic miss);
    mode    = MODE_PLAIN;
    esc_val = '0;
    digits  = '0;
    push_byte(8'h00, 1'b1, miss);
  endtask

  // character in plain text
  task automatic plain_char(logic [7:0] c, logic eoi);
    mode = MODE_PLAIN;
    if (eoi || c == CH_LF) begin
      end_string(1'b1);
    end else if (c == CH_QUOTE) begin
      end_string(1'b0);
    end else if (c == CH_BSLASH) begin
      mode = MODE_ESC;
    end else begin
      push_byte(c, 1'b0, 1'b0);
      if (dbl_en && is_lead_byte(c)) mode = MODE_TRAIL;
    end
  endtask

  // character right after a backslash
  task automatic escape_char(logic [7:0] c, logic eoi);
    if (eoi) begin
      end_string(1'b1);
    end else begin
      mode = MODE_PLAIN;
      if (c == CH_LF) begin
        // line continuation, nothing out
      end else if (c >= CH_ZERO && c <= CH_SEVEN) begin
        esc_val = c - CH_ZERO;
        digits  = 2'd1;
        mode    = MODE_OCT;
      end else if (c == CH_LOW_X) begin
        esc_val = '0;
        digits  = '0;
        mode    = MODE_HEX;
      end else begin
        push_byte(escape_code(c), 1'b0, 1'b0);
      end
    end
  endtask

  // expected results of one input transaction
  task automatic decode_char(in_item_t it);
    logic [7:0] c;
    logic       eoi;
    int         d;
    c   = it.in_char;
    eoi = it.end_of_input;
    case (mode)
      MODE_ESC: escape_char(c, eoi);
      MODE_OCT: begin
        if (!eoi && c >= CH_ZERO && c <= CH_SEVEN && digits < 2'd3) begin
          esc_val = esc_val * 8'd8 + (c - CH_ZERO);
          digits  = digits + 2'd1;
          if (digits == 2'd3) begin
            mode   = MODE_PLAIN;
            digits = '0;
            push_byte(esc_val, 1'b0, 1'b0);
          end
        end else begin
          push_byte(esc_val, 1'b0, 1'b0);
          digits = '0;
          plain_char(c, eoi);
        end
      end
      MODE_HEX: begin
        d = eoi ? -1 : hex_value(c);
        if (d >= 0) begin
          esc_val = esc_val * 8'd16 + 8'(d);
          digits  = digits + 2'd1;
          if (digits == 2'd2) begin
            mode   = MODE_PLAIN;
            digits = '0;
            push_byte(esc_val, 1'b0, 1'b0);
          end
        end else begin
          push_byte(esc_val, 1'b0, 1'b0);
          digits = '0;
          plain_char(c, eoi);
        end
      end
      MODE_TRAIL: begin
        if (eoi) begin
          end_string(1'b1);
        end else begin
          mode = MODE_PLAIN;
          push_byte(c, 1'b0, 1'b0);
        end
      end
      default: plain_char(c, eoi);
    endcase
  endtask

  // watch the three channels, compare results, then predict
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbl_en       = 1'b1;
      mode         = MODE_PLAIN;
      esc_val      = '0;
      digits       = '0;
      decoded_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected result: out_byte %h last %b missing_quote %b",
                 out_item_i.out_byte, out_item_i.last, out_item_i.missing_quote);
          fail_count_o++;
        end else begin
          want = decoded_q.pop_front();
          if (out_item_i.out_byte !== want.out_byte) begin
            $error("out_byte expected %h actual %h", want.out_byte, out_item_i.out_byte);
            fail_count_o++;
          end
          if (out_item_i.last !== want.last) begin
            $error("last expected %b actual %b", want.last, out_item_i.last);
            fail_count_o++;
          end
          if (out_item_i.missing_quote !== want.missing_quote) begin
            $error("missing_quote expected %b actual %b",
                   want.missing_quote, out_item_i.missing_quote);
            fail_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) dbl_en = cfg_data_i;
      if (in_valid_i && in_ready_i) decode_char(in_item_i);
      pending_o = decoded_q.size();
    end
  end

endmodule

### test/string_literal_escape_decoder_tb.sv
module string_literal_escape_decoder_tb import sled_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic      cfg_data_i;
  int        fail_count;
  int        pending;
  int        sent;
  bit        calm;

  string_literal_escape_decoder u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  string_literal_decode_checker u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_i  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // result side stalls at random
  initial out_ready_i = 1'b0;
  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 22);
  end

  // one input transaction, with a random gap ahead of it
  task automatic send_char(logic [7:0] c, logic eoi);
    while (!calm && $urandom_range(99) < 22) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i             <= 1'b1;
    in_item_i.in_char      <= c;
    in_item_i.end_of_input <= eoi;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent++;
  endtask

  // hold input until every expected result is out and the pipe is empty
  task automatic settle_idle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_double_byte(logic v);
    settle_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] any_hex_digit();
    int v;
    v = $urandom_range(21);
    if (v < 10) return 8'h30 + 8'(v);
    if (v < 16) return 8'h41 + 8'(v - 10);
    return 8'h61 + 8'(v - 16);
  endfunction

  // any byte that stays literal text in plain mode
  function automatic logic [7:0] text_byte(bit printable);
    logic [7:0] c;
    do begin
      c = printable ? 8'($urandom_range(32, 126)) : 8'($urandom_range(255));
    end while (c == CH_QUOTE || c == CH_BSLASH || c == CH_LF);
    return c;
  endfunction

  function automatic logic [7:0] escape_letter();
    case ($urandom_range(6))
      0: return CH_LOW_N;
      1: return CH_LOW_T;
      2: return CH_LOW_B;
      3: return CH_LOW_R;
      4: return CH_LOW_F;
      5: return CH_LOW_V;
      default: return CH_LOW_A;
    endcase
  endfunction

  // one well-formed piece of literal body
  task automatic send_token();
    case ($urandom_range(9))
      0, 1, 2: send_char(text_byte(1'b1), 1'b0);
      3: send_char(text_byte(1'b0), 1'b0);
      4: begin
        send_char(CH_BSLASH, 1'b0);
        send_char(escape_letter(), 1'b0);
      end
      5: begin
        send_char(CH_BSLASH, 1'b0);
        repeat ($urandom_range(1, 3)) send_char(8'h30 + 8'($urandom_range(7)), 1'b0);
      end
      6: begin
        send_char(CH_BSLASH, 1'b0);
        send_char(CH_LOW_X, 1'b0);
        repeat ($urandom_range(2)) send_char(any_hex_digit(), 1'b0);
      end
      7: begin
        send_char($urandom_range(1) ? 8'($urandom_range(8'h81, 8'h9F))
                                    : 8'($urandom_range(8'hE0, 8'hFC)), 1'b0);
        send_char(8'($urandom_range(255)), 1'b0);
      end
      8: begin
        send_char(CH_BSLASH, 1'b0);
        send_char(CH_LF, 1'b0);
      end
      default: begin
        send_char(CH_BSLASH, 1'b0);
        send_char(8'($urandom_range(255)), 1'b0);
      end
    endcase
  endtask

  // a whole literal body, mostly closed by a quote
  task automatic send_string();
    int r;
    repeat ($urandom_range(10)) send_token();
    r = $urandom_range(99);
    if (r < 80) send_char(CH_QUOTE, 1'b0);
    else if (r < 90) send_char(CH_LF, 1'b0);
    else send_char(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic random_until(int target);
    while (sent < target) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 4))
          send_char(8'($urandom_range(255)), $urandom_range(19) == 0);
      end else begin
        send_string();
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = 1'b0;
    calm        = 1'b0;
    sent        = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, double-byte mode on from reset
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(CH_BSLASH, 1'b0);
    send_char(CH_LOW_N, 1'b0);
    send_char(CH_BSLASH, 1'b0);
    send_char("q", 1'b0);
    // octal escape that wraps
    send_char(CH_BSLASH, 1'b0);
    repeat (3) send_char("7", 1'b0);
    // hex escape cut short by a plain char
    send_char(CH_BSLASH, 1'b0);
    send_char(CH_LOW_X, 1'b0);
    send_char("A", 1'b0);
    send_char("g", 1'b0);
    // lead byte then a quote taken raw
    send_char(8'h81, 1'b0);
    send_char(CH_QUOTE, 1'b0);
    // escaped lead byte stands alone
    send_char(CH_BSLASH, 1'b0);
    send_char(8'h9F, 1'b0);
    send_char(CH_LOW_A, 1'b0);
    // continuation
    send_char(CH_BSLASH, 1'b0);
    send_char(CH_LF, 1'b0);
    // hex escape with no digits, then the closing quote
    send_char(CH_BSLASH, 1'b0);
    send_char(CH_LOW_X, 1'b0);
    send_char(CH_QUOTE, 1'b0);
    // octal escape then end of input
    send_char(CH_BSLASH, 1'b0);
    send_char("1", 1'b0);
    send_char(8'hA5, 1'b1);
    // backslash then end of input, newline end, trail then end of input
    send_char(CH_BSLASH, 1'b0);
    send_char(8'h5A, 1'b1);
    send_char(CH_LF, 1'b0);
    send_char(8'hFC, 1'b0);
    send_char(8'h00, 1'b1);

    // random phases across both register settings
    write_double_byte(1'b0);
    random_until(190);
    write_double_byte(1'b1);
    calm = 1'b1;
    random_until(280);
    calm = 1'b0;
    random_until(360);
    settle_idle();
    random_until(400);
    write_double_byte(1'b0);
    random_until(470);
    write_double_byte(1'b1);
    random_until(575);

    // drain and verdict
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
